// ===== src/hctl_pkg.sv =====
// Package: request/result types and opcode constants for the Huffman code table lookup.
package hctl_pkg;

  // Opcodes
  localparam logic OP_STORE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // Legal code length range
  localparam logic [4:0] LEN_MIN = 5'd1;
  localparam logic [4:0] LEN_MAX = 5'd16;

  // Input request as it arrives on the port
  typedef struct packed {
    logic        opcode;
    logic [1:0]  table_select;
    logic [4:0]  code_length;
    logic [15:0] code_bits;
    logic [7:0]  symbol;
  } in_req_t;

  // Result item
  typedef struct packed {
    logic       found;
    logic [7:0] symbol_out;
    logic       table_full;
  } out_res_t;

  // Classified request passed from front to back through the queue
  typedef struct packed {
    logic        ok;
    logic        opcode;
    logic [1:0]  table_select;
    logic [4:0]  code_length;
    logic [15:0] code_bits;
    logic [7:0]  symbol;
  } cls_req_t;

  // One stored table entry
  typedef struct packed {
    logic [4:0]  len;
    logic [15:0] code;
    logic [7:0]  sym;
  } entry_t;

endpackage

// ===== src/hctl_front.sv =====
// Front end: takes requests, checks range, masks code bits and holds the classified request.
module hctl_front #(
  parameter int TABLE_COUNT = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  hctl_pkg::in_req_t   in_req,
  output logic                busy,
  output logic                push,
  output hctl_pkg::cls_req_t  push_item,
  input  logic                q_full
);

  logic               vld_r;
  logic               vld_nxt;
  hctl_pkg::cls_req_t item_r;
  hctl_pkg::cls_req_t cls;
  logic               take;
  logic [15:0]        len_mask;

  // Mask of the low code_length bits (lengths above 16 are rejected anyway)
  always_comb begin
    len_mask = '0;
    for (int i = 0; i < 16; i++) begin
      len_mask[i] = (5'(i) < in_req.code_length);
    end
  end

  // Classification of the incoming request
  always_comb begin
    cls.ok = (32'(in_req.table_select) < TABLE_COUNT) &&
             (in_req.code_length >= hctl_pkg::LEN_MIN) &&
             (in_req.code_length <= hctl_pkg::LEN_MAX);
    cls.opcode       = in_req.opcode;
    cls.table_select = in_req.table_select;
    cls.code_length  = in_req.code_length;
    cls.code_bits    = in_req.code_bits & len_mask;
    cls.symbol       = in_req.symbol;
  end

  assign push      = vld_r && !q_full;
  assign push_item = item_r;
  assign busy      = vld_r && q_full;
  assign take      = start && !busy;

  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (push) begin
      vld_nxt = 1'b0;
    end
  end

  // Holding register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    if (take) begin
      item_r <= cls;
    end
  end

endmodule

// ===== src/hctl_queue.sv =====
// Two-entry queue of classified requests between front and back.
module hctl_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  hctl_pkg::cls_req_t  push_item,
  input  logic                pop,
  output hctl_pkg::cls_req_t  head,
  output logic                empty,
  output logic                full
);

  hctl_pkg::cls_req_t slot_r [2];
  logic               wr_ptr_r;
  logic               rd_ptr_r;
  logic [1:0]         cnt_r;
  logic [1:0]         cnt_nxt;

  assign empty = (cnt_r == 2'd0);
  assign full  = (cnt_r == 2'd2);
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  // Pointers and storage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== src/hctl_back.sv =====
// Back end: scans the entry memory of the selected table, stores or looks up, drives results.
module hctl_back #(
  parameter int ENTRIES_PER_TABLE = 256,
  parameter int TABLE_COUNT       = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  hctl_pkg::cls_req_t  head,
  input  logic                q_empty,
  output logic                pop,
  output logic                out_valid,
  output hctl_pkg::out_res_t  out_res
);

  localparam int TOTAL  = ENTRIES_PER_TABLE * TABLE_COUNT;
  localparam int ADDR_W = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int TIDX_W = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;
  localparam int CNT_W  = $clog2(ENTRIES_PER_TABLE + 1);
  localparam logic [ADDR_W-1:0] EPT_A = ADDR_W'(ENTRIES_PER_TABLE);
  localparam logic [CNT_W-1:0]  EPT_C = CNT_W'(ENTRIES_PER_TABLE);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  // Entry memory, one port read and one port write per cycle
  hctl_pkg::entry_t mem [TOTAL];
  hctl_pkg::entry_t rd_data_r;

  logic                  state_r, state_nxt;
  logic [CNT_W-1:0]      fill_r [TABLE_COUNT];
  hctl_pkg::cls_req_t    req_r;
  logic [TIDX_W-1:0]     tbl_r;
  logic [ADDR_W-1:0]     base_r;
  logic [CNT_W-1:0]      rd_idx_r, rd_idx_nxt;
  logic                  cmp_vld_r, cmp_vld_nxt;
  logic [ADDR_W-1:0]     cmp_addr_r, cmp_addr_nxt;
  logic [CNT_W-1:0]      fill_cur;
  logic                  hit;
  logic                  miss;
  logic                  rd_en;
  logic [ADDR_W-1:0]     rd_addr;
  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  hctl_pkg::entry_t      wr_data;
  logic                  fill_inc;
  logic                  load;
  logic [TIDX_W-1:0]     head_tbl;
  logic                  res_vld_nxt;
  hctl_pkg::out_res_t    res_nxt;
  logic                  out_valid_r;
  hctl_pkg::out_res_t    out_res_r;

  assign head_tbl = TIDX_W'(head.table_select);
  assign fill_cur = fill_r[tbl_r];
  assign pop      = (state_r == ST_IDLE) && !q_empty;
  assign load     = pop && head.ok;

  // Compare of the entry read in the previous cycle
  assign hit  = (state_r == ST_SCAN) && cmp_vld_r &&
                (rd_data_r.len == req_r.code_length) &&
                (rd_data_r.code == req_r.code_bits);
  assign miss = (state_r == ST_SCAN) && !hit && (rd_idx_r == fill_cur);

  // Scan control, memory write decision and result
  always_comb begin
    state_nxt    = state_r;
    rd_idx_nxt   = rd_idx_r;
    cmp_vld_nxt  = 1'b0;
    cmp_addr_nxt = cmp_addr_r;
    rd_en        = 1'b0;
    rd_addr      = base_r + ADDR_W'(rd_idx_r);
    wr_en        = 1'b0;
    wr_addr      = cmp_addr_r;
    wr_data.len  = req_r.code_length;
    wr_data.code = req_r.code_bits;
    wr_data.sym  = req_r.symbol;
    fill_inc     = 1'b0;
    res_vld_nxt  = 1'b0;
    res_nxt      = '0;
    case (state_r)
      ST_IDLE: begin
        if (pop && !head.ok) begin
          // Out-of-range request: empty result right away
          res_vld_nxt = 1'b1;
        end else if (load) begin
          state_nxt  = ST_SCAN;
          rd_idx_nxt = '0;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          state_nxt   = ST_IDLE;
          res_vld_nxt = 1'b1;
          if (req_r.opcode == hctl_pkg::OP_STORE) begin
            wr_en = 1'b1;
          end else begin
            res_nxt.found      = 1'b1;
            res_nxt.symbol_out = rd_data_r.sym;
          end
        end else if (miss) begin
          state_nxt   = ST_IDLE;
          res_vld_nxt = 1'b1;
          if (req_r.opcode == hctl_pkg::OP_STORE) begin
            if (fill_cur < EPT_C) begin
              wr_en    = 1'b1;
              wr_addr  = base_r + ADDR_W'(fill_cur);
              fill_inc = 1'b1;
            end else begin
              res_nxt.table_full = 1'b1;
            end
          end
        end else begin
          rd_en        = 1'b1;
          rd_idx_nxt   = rd_idx_r + CNT_W'(1);
          cmp_vld_nxt  = 1'b1;
          cmp_addr_nxt = rd_addr;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Memory: overwrite keeps key and replaces symbol, a new entry writes all fields
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Control state and fill counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
      for (int t = 0; t < TABLE_COUNT; t++) begin
        fill_r[t] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= res_vld_nxt;
      if (fill_inc) begin
        fill_r[tbl_r] <= fill_cur + CNT_W'(1);
      end
    end
  end

  // Request and scan registers
  always_ff @(posedge clk) begin
    rd_idx_r   <= rd_idx_nxt;
    cmp_addr_r <= cmp_addr_nxt;
    out_res_r  <= res_nxt;
    if (load) begin
      req_r  <= head;
      tbl_r  <= head_tbl;
      base_r <= ADDR_W'(head_tbl) * EPT_A;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

// ===== src/huffman_code_table_lookup.sv =====
// Top level: JPEG Huffman code tables with store and lookup requests.
//
// A request is taken when start is high and busy is low; each request gives exactly one
// result, shown for one cycle with out_valid high, in request order, and the receiver
// cannot stall it. A front register and a two-entry queue take requests while the back
// end works, so busy only rises when both are occupied. The back end scans the selected
// table's entries in fill order through the single read port of the entry memory, one
// entry per cycle, and stops at the first match or after the last filled entry. A
// request with a table select or code length out of range yields an empty result without
// a scan. Fill counts clear at reset and mark the valid entries, so no clearing pass is
// needed.
module huffman_code_table_lookup #(
  parameter int ENTRIES_PER_TABLE = 256,
  parameter int TABLE_COUNT       = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  hctl_pkg::in_req_t  in_req,
  output logic               busy,
  output logic               out_valid,
  output hctl_pkg::out_res_t out_res
);

  logic               push;
  hctl_pkg::cls_req_t push_item;
  logic               q_full;
  logic               q_empty;
  logic               pop;
  hctl_pkg::cls_req_t head;

  hctl_front #(
    .TABLE_COUNT(TABLE_COUNT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_req   (in_req),
    .busy     (busy),
    .push     (push),
    .push_item(push_item),
    .q_full   (q_full)
  );

  hctl_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_item(push_item),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  hctl_back #(
    .ENTRIES_PER_TABLE(ENTRIES_PER_TABLE),
    .TABLE_COUNT      (TABLE_COUNT)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .q_empty  (q_empty),
    .pop      (pop),
    .out_valid(out_valid),
    .out_res  (out_res)
  );

endmodule

// ===== dv/huffman_code_table_lookup_tb.sv =====
// Testbench for huffman_code_table_lookup: directed table, full-table fill, random traffic.
module huffman_code_table_lookup_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLES      = 4;
  localparam int SLOTS       = 256;
  localparam int RANDOM_REQS = 740;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int NUM_DIRECTED = 23;

  // Directed rows either expect an all-zero result or defer to the predictor
  localparam bit ZERO_RES  = 1'b1;
  localparam bit PREDICTED = 1'b0;

  typedef struct packed {
    hctl_pkg::in_req_t req;
    logic              zero_res;
  } dir_row_t;

  typedef struct packed {
    logic [1:0]  tsel;
    logic [4:0]  len;
    logic [15:0] key;
  } code_key_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  hctl_pkg::in_req_t  in_req = '0;
  logic               busy;
  logic               out_valid;
  hctl_pkg::out_res_t out_res;

  // Predictor copy of the code tables; slots below fill_level are valid
  logic [4:0]  code_len_mem [TABLES][SLOTS];
  logic [15:0] code_key_mem [TABLES][SLOTS];
  logic [7:0]  code_sym_mem [TABLES][SLOTS];
  int          fill_level [TABLES];

  hctl_pkg::out_res_t pending_results [$];
  code_key_t          stored_keys [$];
  int                 fail_count = 0;
  int                 cycle_count = 0;
  int                 burst_left = 0;

  // op, table, length, bits, symbol, expectation
  dir_row_t directed_rows [NUM_DIRECTED] = '{
    {hctl_pkg::OP_LOOKUP, 2'd0, 5'd1,  16'h0000, 8'h00, ZERO_RES},   // empty table after reset
    {hctl_pkg::OP_STORE,  2'd0, 5'd1,  16'h0000, 8'h00, ZERO_RES},
    {hctl_pkg::OP_STORE,  2'd0, 5'd1,  16'h0001, 8'hFF, ZERO_RES},
    {hctl_pkg::OP_LOOKUP, 2'd0, 5'd1,  16'hFFFE, 8'h00, PREDICTED},  // bits above length ignored
    {hctl_pkg::OP_LOOKUP, 2'd0, 5'd1,  16'h0001, 8'h00, PREDICTED},
    {hctl_pkg::OP_STORE,  2'd0, 5'd16, 16'hFFFF, 8'hA5, ZERO_RES},
    {hctl_pkg::OP_LOOKUP, 2'd0, 5'd16, 16'hFFFF, 8'h00, PREDICTED},
    {hctl_pkg::OP_LOOKUP, 2'd0, 5'd15, 16'h7FFF, 8'h00, PREDICTED},  // same bits, other length
    {hctl_pkg::OP_STORE,  2'd0, 5'd16, 16'hFFFF, 8'h5A, ZERO_RES},   // overwrite
    {hctl_pkg::OP_LOOKUP, 2'd0, 5'd16, 16'hFFFF, 8'h00, PREDICTED},
    {hctl_pkg::OP_STORE,  2'd0, 5'd0,  16'h0000, 8'h11, ZERO_RES},   // zero length dropped
    {hctl_pkg::OP_LOOKUP, 2'd0, 5'd0,  16'h0000, 8'h00, ZERO_RES},
    {hctl_pkg::OP_STORE,  2'd1, 5'd17, 16'hFFFF, 8'h22, ZERO_RES},   // length too long
    {hctl_pkg::OP_LOOKUP, 2'd1, 5'd31, 16'hFFFF, 8'h00, ZERO_RES},
    {hctl_pkg::OP_STORE,  2'd3, 5'd16, 16'h0000, 8'h33, ZERO_RES},
    {hctl_pkg::OP_LOOKUP, 2'd2, 5'd16, 16'h0000, 8'h00, PREDICTED},  // tables are separate
    {hctl_pkg::OP_LOOKUP, 2'd3, 5'd16, 16'h0000, 8'h00, PREDICTED},
    {hctl_pkg::OP_STORE,  2'd1, 5'd8,  16'h1234, 8'h77, ZERO_RES},
    {hctl_pkg::OP_LOOKUP, 2'd1, 5'd8,  16'h0034, 8'hFF, PREDICTED},  // symbol ignored on lookup
    {hctl_pkg::OP_LOOKUP, 2'd1, 5'd8,  16'hAB34, 8'h00, PREDICTED},
    {hctl_pkg::OP_LOOKUP, 2'd2, 5'd8,  16'h0034, 8'h00, PREDICTED},
    {hctl_pkg::OP_STORE,  2'd2, 5'd5,  16'h0015, 8'h80, ZERO_RES},
    {hctl_pkg::OP_LOOKUP, 2'd2, 5'd5,  16'hFFF5, 8'h00, PREDICTED}
  };

  huffman_code_table_lookup #(
    .ENTRIES_PER_TABLE(SLOTS),
    .TABLE_COUNT      (TABLES)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_req   (in_req),
    .busy     (busy),
    .out_valid(out_valid),
    .out_res  (out_res)
  );

  always #2 clk = ~clk;

  // Applies one request to the predicted tables and returns its result
  function automatic hctl_pkg::out_res_t code_table_access(hctl_pkg::in_req_t r);
    hctl_pkg::out_res_t res;
    logic [16:0]        mask;
    logic [15:0]        key;
    int                 t;
    int                 hit;
    res = '0;
    t = int'(r.table_select);
    if (t >= TABLES || r.code_length < hctl_pkg::LEN_MIN ||
        r.code_length > hctl_pkg::LEN_MAX) return res;
    mask = (17'd1 << r.code_length) - 17'd1;
    key = r.code_bits & mask[15:0];
    hit = -1;
    for (int s = 0; s < fill_level[t]; s++) begin
      if (code_len_mem[t][s] == r.code_length && code_key_mem[t][s] == key) begin
        hit = s;
        break;
      end
    end
    if (r.opcode == hctl_pkg::OP_STORE) begin
      if (hit >= 0) begin
        code_sym_mem[t][hit] = r.symbol;
      end else if (fill_level[t] < SLOTS) begin
        code_len_mem[t][fill_level[t]] = r.code_length;
        code_key_mem[t][fill_level[t]] = key;
        code_sym_mem[t][fill_level[t]] = r.symbol;
        fill_level[t]++;
      end else begin
        res.table_full = 1'b1;
      end
    end else if (hit >= 0) begin
      res.found = 1'b1;
      res.symbol_out = code_sym_mem[t][hit];
    end
    return res;
  endfunction

  // Sender gap: back-to-back requests inside a burst, a short or long gap between bursts
  function automatic int next_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    burst_left = $urandom_range(0, 20);
    if ($urandom_range(0, 3) == 0) return $urandom_range(20, 300);
    return $urandom_range(1, 8);
  endfunction

  // Random request; most reuse a stored key so lookups hit and stores overwrite
  function automatic hctl_pkg::in_req_t random_request();
    hctl_pkg::in_req_t r;
    code_key_t         k;
    logic [16:0]       mask;
    r.opcode = $urandom_range(0, 1) ? hctl_pkg::OP_LOOKUP : hctl_pkg::OP_STORE;
    r.table_select = 2'($urandom_range(0, 3));
    r.code_bits = 16'($urandom);
    r.symbol = 8'($urandom);
    if ($urandom_range(0, 9) == 0) begin
      r.code_length = $urandom_range(0, 1) ? 5'($urandom_range(17, 31)) : 5'd0;
    end else begin
      r.code_length = 5'($urandom_range(1, 16));
    end
    if (stored_keys.size() != 0 && $urandom_range(0, 9) < 6) begin
      k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
      r.table_select = k.tsel;
      r.code_length = k.len;
      mask = (17'd1 << k.len) - 17'd1;
      r.code_bits = (r.code_bits & ~mask[15:0]) | k.key;
    end
    if (r.opcode == hctl_pkg::OP_STORE && r.code_length >= hctl_pkg::LEN_MIN &&
        r.code_length <= hctl_pkg::LEN_MAX) begin
      mask = (17'd1 << r.code_length) - 17'd1;
      k.tsel = r.table_select;
      k.len = r.code_length;
      k.key = r.code_bits & mask[15:0];
      stored_keys.push_back(k);
      if (stored_keys.size() > 48) void'(stored_keys.pop_front());
    end
    return r;
  endfunction

  // Drives one request after a sender gap and records its expected result
  task automatic issue(input hctl_pkg::in_req_t r, input bit zero_res);
    int                 gap;
    hctl_pkg::out_res_t res;
    gap = next_gap();
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
      in_req <= hctl_pkg::in_req_t'($urandom);
    end
    @(negedge clk);
    start <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (busy);
    res = code_table_access(r);
    pending_results.push_back(zero_res ? hctl_pkg::out_res_t'('0) : res);
  endtask

  // Holds the sender off until every request has its result
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Result checker
  always @(posedge clk) begin : result_check
    hctl_pkg::out_res_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result with no request pending: %h", out_res);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_res.found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, out_res.found);
          fail_count++;
        end
        if (out_res.symbol_out !== want.symbol_out) begin
          $error("symbol_out: expected %h, got %h", want.symbol_out, out_res.symbol_out);
          fail_count++;
        end
        if (out_res.table_full !== want.table_full) begin
          $error("table_full: expected %0d, got %0d", want.table_full, out_res.table_full);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("huffman_code_table_lookup_tb NOT OK");
      $finish;
    end
  end

  initial begin
    hctl_pkg::in_req_t r;
    foreach (fill_level[t]) fill_level[t] = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Directed table
    foreach (directed_rows[i]) issue(directed_rows[i].req, directed_rows[i].zero_res);
    drain();

    // Fill table 3 with long codes until no slot is left
    while (fill_level[3] < SLOTS) begin
      r = {hctl_pkg::OP_STORE, 2'd3, 5'd16, 16'($urandom), 8'($urandom)};
      issue(r, PREDICTED);
    end
    // Full table: new code dropped, overwrite still works, last slot reachable
    issue({hctl_pkg::OP_STORE, 2'd3, 5'd3, 16'h0005, 8'h44}, PREDICTED);
    issue({hctl_pkg::OP_STORE, 2'd3, 5'd16, 16'h0000, 8'hC3}, PREDICTED);
    issue({hctl_pkg::OP_LOOKUP, 2'd3, 5'd16, 16'h0000, 8'h00}, PREDICTED);
    issue({hctl_pkg::OP_LOOKUP, 2'd3, 5'd16, code_key_mem[3][SLOTS-1], 8'h00}, PREDICTED);
    issue({hctl_pkg::OP_LOOKUP, 2'd3, 5'd3, 16'h0005, 8'h00}, PREDICTED);
    drain();

    // Random traffic over all tables
    repeat (RANDOM_REQS) issue(random_request(), PREDICTED);

    drain();
    repeat (SLOTS + 8) @(posedge clk);
    if (fail_count == 0) begin
      $display("huffman_code_table_lookup_tb OK");
    end else begin
      $display("huffman_code_table_lookup_tb NOT OK");
    end
    $finish;
  end

endmodule
